/* rtl/astb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astb_pkg
// Types, constants and codes shared by the allocation sample trace buffer.
// ----------------------------------------------------------------------------
package astb_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int MAX_FRAMES_DEF = 64;

  localparam int RATE_W  = 31;
  localparam int SIZE_W  = 48;
  localparam int PC_W    = 64;
  localparam int SEED_W  = 64;
  localparam int NFRM_W  = 7;
  localparam int CFG_W   = 64;
  localparam int CFGI_W  = 2;

  localparam logic [SEED_W-1:0] SEED_RESET = 64'd88172645463325252;

  localparam logic [CFGI_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_ENABLE      = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_SEED        = 2'd2;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_END   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DECISION = 2'd0,
    KIND_FRAME    = 2'd1,
    KIND_EMPTY    = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MOD_WAIT,
    ST_COPY,
    ST_RD_PRE,
    ST_RD_STREAM
  } state_t;

  typedef struct packed {
    cmd_t               command;
    logic [SIZE_W-1:0]  alloc_size;
    logic [PC_W-1:0]    frame_pc;
    logic [NFRM_W-1:0]  max_frames;
  } in_item_t;

  typedef struct packed {
    kind_t              result_kind;
    logic               sampled;
    logic [PC_W-1:0]    record_pc;
    logic [SIZE_W-1:0]  record_size;
    logic [NFRM_W-1:0]  record_frames;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic emit_dec;
    logic dec_smp;
    logic gen_step;
    logic frame_push;
    logic copy_start;
    logic copy_run;
    logic commit;
    logic close;
    logic emit_nrdy;
    logic consume;
    logic stream_emit;
  } ctl_t;

  typedef struct packed {
    cmd_t command;
    logic rate_off;
    logic force_smp;
    logic mod_done;
    logic mod_le;
    logic can_commit;
    logic copy_done;
    logic rd_ready;
    logic n_zero;
    logic last_k;
  } sts_t;

endpackage

/* rtl/astb_mod.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// astb_mod
// Iterative remainder of a 64-bit value by a 31-bit divisor, two bits a cycle.
// ----------------------------------------------------------------------------
module astb_mod (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [astb_pkg::SEED_W-1:0]  dividend,
  input  wire logic [astb_pkg::RATE_W-1:0]  divisor,
  output logic                              done,
  output logic [astb_pkg::RATE_W-1:0]       rem
);

  localparam int DW = astb_pkg::SEED_W;
  localparam int RW = astb_pkg::RATE_W;
  localparam int ITERS = DW / 2;
  localparam int IW = $clog2(ITERS);

  logic [DW-1:0] q_r, q_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] div_r;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    logic [RW:0]   r;
    logic [RW-1:0] rv;
    logic [DW-1:0] qv;
    rv = rem_r;
    qv = q_r;
    for (int j = 0; j < 2; j++) begin
      r  = {rv, qv[DW-1]};
      qv = {qv[DW-2:0], 1'b0};
      if (r >= {1'b0, div_r}) begin
        r = r - {1'b0, div_r};
      end
      rv = r[RW-1:0];
    end
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
    end else if (run_r) begin
      q_nxt   = qv;
      rem_nxt = rv;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == IW'(ITERS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

/* rtl/astb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// astb_ctrl
// Controller state machine that sequences each command through the datapath.
// ----------------------------------------------------------------------------
module astb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire astb_pkg::sts_t   sts,
  output astb_pkg::ctl_t        ctl
);

  astb_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      astb_pkg::ST_IDLE: begin
        if (start) state_nxt = astb_pkg::ST_DISPATCH;
      end
      astb_pkg::ST_DISPATCH: begin
        case (sts.command)
          astb_pkg::CMD_ALLOC: begin
            if (sts.rate_off || sts.force_smp) state_nxt = astb_pkg::ST_IDLE;
            else state_nxt = astb_pkg::ST_MOD_WAIT;
          end
          astb_pkg::CMD_END: begin
            state_nxt = sts.can_commit ? astb_pkg::ST_COPY : astb_pkg::ST_IDLE;
          end
          astb_pkg::CMD_READ: begin
            if (!sts.rd_ready || sts.n_zero) state_nxt = astb_pkg::ST_IDLE;
            else state_nxt = astb_pkg::ST_RD_PRE;
          end
          default: state_nxt = astb_pkg::ST_IDLE;
        endcase
      end
      astb_pkg::ST_MOD_WAIT: begin
        if (sts.mod_done) state_nxt = astb_pkg::ST_IDLE;
      end
      astb_pkg::ST_COPY: begin
        if (sts.copy_done) state_nxt = astb_pkg::ST_IDLE;
      end
      astb_pkg::ST_RD_PRE: state_nxt = astb_pkg::ST_RD_STREAM;
      astb_pkg::ST_RD_STREAM: begin
        if (sts.last_k) state_nxt = astb_pkg::ST_IDLE;
      end
      default: state_nxt = astb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      astb_pkg::ST_IDLE: ctl.latch = start;
      astb_pkg::ST_DISPATCH: begin
        case (sts.command)
          astb_pkg::CMD_ALLOC: begin
            if (sts.rate_off) begin
              ctl.emit_dec = 1'b1;
            end else if (sts.force_smp) begin
              ctl.emit_dec = 1'b1;
              ctl.dec_smp  = 1'b1;
            end else begin
              ctl.gen_step = 1'b1;
            end
          end
          astb_pkg::CMD_FRAME: ctl.frame_push = 1'b1;
          astb_pkg::CMD_END: begin
            if (sts.can_commit) ctl.copy_start = 1'b1;
            else ctl.close = 1'b1;
          end
          astb_pkg::CMD_READ: begin
            if (sts.rd_ready) ctl.consume = 1'b1;
            else ctl.emit_nrdy = 1'b1;
          end
          default: ;
        endcase
      end
      astb_pkg::ST_MOD_WAIT: begin
        ctl.emit_dec = sts.mod_done;
        ctl.dec_smp  = sts.mod_le;
      end
      astb_pkg::ST_COPY: begin
        ctl.copy_run = 1'b1;
        ctl.commit   = sts.copy_done;
      end
      astb_pkg::ST_RD_STREAM: ctl.stream_emit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= astb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != astb_pkg::ST_IDLE);

endmodule
`default_nettype wire

/* rtl/astb_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// astb_dp
// Datapath: configuration, generator, open record, record store and output.
// ----------------------------------------------------------------------------
module astb_dp #(
  parameter int SLOTS      = astb_pkg::SLOTS_DEF,
  parameter int MAX_FRAMES = astb_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [astb_pkg::CFGI_W-1:0]  cfg_index,
  input  wire logic [astb_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire astb_pkg::in_item_t           in_data,
  input  wire astb_pkg::ctl_t               ctl,
  output astb_pkg::sts_t                    sts,
  output logic                              out_strobe,
  output astb_pkg::out_item_t               out_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int FS_DEPTH = SLOTS * (2 ** FW);
  localparam int NW = astb_pkg::NFRM_W;
  localparam int ZW = astb_pkg::SIZE_W;

  logic [astb_pkg::RATE_W-1:0] rate_r;
  logic                        en_r;
  logic [astb_pkg::SEED_W-1:0] seed_r;
  astb_pkg::in_item_t          item_r;
  logic [astb_pkg::SEED_W-1:0] gen_r;
  logic [astb_pkg::SEED_W-1:0] gen_x;

  logic          open_r;
  logic [CW-1:0] ocnt_r;
  logic [ZW-1:0] osize_r;

  logic [SW-1:0]    wslot_r, rslot_r, sslot_r;
  logic [SLOTS-1:0] ready_r;

  logic [astb_pkg::PC_W-1:0] obuf [2**FW];
  logic [astb_pkg::PC_W-1:0] ob_q;
  logic [CW-1:0]             cidx_r;
  logic                      wv_r;
  logic [CW-1:0]             waddr_r;

  logic [astb_pkg::PC_W-1:0] fstore [FS_DEPTH];
  logic [astb_pkg::PC_W-1:0] fs_q;
  logic [SW+FW-1:0]          fs_raddr;
  logic [CW-1:0]             cmem [SLOTS];
  logic [ZW-1:0]             zmem [SLOTS];
  logic [CW-1:0]             cnt_q;
  logic [ZW-1:0]             size_q;

  logic [NW-1:0] n_r, n_c, cnt7;
  logic [CW-1:0] k_r, k_nxt;
  logic [ZW-1:0] ssize_r;

  logic                        mod_done;
  logic [astb_pkg::RATE_W-1:0] mod_rem;

  astb_pkg::out_item_t out_r, out_nxt;
  logic                out_v_r, out_v_nxt;

  always_comb begin
    logic [astb_pkg::SEED_W-1:0] x;
    x = (gen_r == '0) ? seed_r : gen_r;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    gen_x = x;
  end

  astb_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.gen_step),
    .dividend (gen_x),
    .divisor  (rate_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign cnt7 = NW'(cnt_q);
  assign n_c  = (cnt7 > item_r.max_frames) ? item_r.max_frames : cnt7;

  always_comb begin
    sts            = '0;
    sts.command    = item_r.command;
    sts.rate_off   = (rate_r == '0) || !en_r;
    sts.force_smp  = (rate_r == astb_pkg::RATE_W'(1))
                     || (item_r.alloc_size > ZW'(rate_r));
    sts.mod_done   = mod_done;
    sts.mod_le     = (ZW'(mod_rem) <= item_r.alloc_size);
    sts.can_commit = open_r && en_r;
    sts.copy_done  = (cidx_r == ocnt_r) && !wv_r;
    sts.rd_ready   = ready_r[rslot_r];
    sts.n_zero     = (n_c == '0);
    sts.last_k     = ((NW'(k_r) + NW'(1)) == n_r);
  end

  always_comb begin
    k_nxt = k_r;
    if (ctl.consume) k_nxt = '0;
    else if (ctl.stream_emit) k_nxt = k_r + 1'b1;
  end
  assign fs_raddr = {sslot_r, k_nxt[FW-1:0]};

  always_comb begin
    out_nxt   = '0;
    out_v_nxt = 1'b0;
    if (ctl.emit_dec) begin
      out_v_nxt           = 1'b1;
      out_nxt.result_kind = astb_pkg::KIND_DECISION;
      out_nxt.sampled     = ctl.dec_smp;
      out_nxt.last        = 1'b1;
    end else if (ctl.emit_nrdy) begin
      out_v_nxt           = 1'b1;
      out_nxt.result_kind = astb_pkg::KIND_NONE;
      out_nxt.last        = 1'b1;
    end else if (ctl.consume && (n_c == '0)) begin
      out_v_nxt           = 1'b1;
      out_nxt.result_kind = astb_pkg::KIND_EMPTY;
      out_nxt.record_size = size_q;
      out_nxt.last        = 1'b1;
    end else if (ctl.stream_emit) begin
      out_v_nxt             = 1'b1;
      out_nxt.result_kind   = astb_pkg::KIND_FRAME;
      out_nxt.record_pc     = fs_q;
      out_nxt.record_size   = ssize_r;
      out_nxt.record_frames = n_r;
      out_nxt.last          = sts.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= '0;
      en_r    <= 1'b0;
      seed_r  <= astb_pkg::SEED_RESET;
      gen_r   <= '0;
      open_r  <= 1'b0;
      ocnt_r  <= '0;
      osize_r <= '0;
      wslot_r <= '0;
      rslot_r <= '0;
      ready_r <= '0;
      wv_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        case (cfg_index)
          astb_pkg::CFG_SAMPLE_RATE: rate_r <= cfg_wdata[astb_pkg::RATE_W-1:0];
          astb_pkg::CFG_ENABLE:      en_r   <= cfg_wdata[0];
          astb_pkg::CFG_SEED:        seed_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (ctl.gen_step) gen_r <= gen_x;
      if (ctl.emit_dec) begin
        open_r  <= ctl.dec_smp;
        ocnt_r  <= '0;
        osize_r <= ctl.dec_smp ? item_r.alloc_size : '0;
      end
      if (ctl.frame_push && open_r && (ocnt_r < CW'(MAX_FRAMES))) begin
        ocnt_r <= ocnt_r + 1'b1;
      end
      if (ctl.close || ctl.commit) begin
        open_r <= 1'b0;
        ocnt_r <= '0;
      end
      wv_r <= ctl.copy_run && (cidx_r < ocnt_r);
      if (ctl.commit) begin
        ready_r[wslot_r] <= 1'b1;
        wslot_r <= (wslot_r == SW'(SLOTS - 1)) ? '0 : wslot_r + 1'b1;
      end
      if (ctl.consume) begin
        ready_r[rslot_r] <= 1'b0;
        rslot_r <= (rslot_r == SW'(SLOTS - 1)) ? '0 : rslot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (ctl.latch) item_r <= in_data;
    if (ctl.copy_start) begin
      cidx_r <= '0;
    end else if (ctl.copy_run && (cidx_r < ocnt_r)) begin
      cidx_r <= cidx_r + 1'b1;
    end
    waddr_r <= cidx_r;
    if (ctl.consume) begin
      sslot_r <= rslot_r;
      n_r     <= n_c;
      ssize_r <= size_q;
    end
    k_r <= k_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.frame_push && open_r && (ocnt_r < CW'(MAX_FRAMES))) begin
      obuf[ocnt_r[FW-1:0]] <= item_r.frame_pc;
    end
    ob_q <= obuf[cidx_r[FW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wv_r) begin
      fstore[{wslot_r, waddr_r[FW-1:0]}] <= ob_q;
    end
    fs_q <= fstore[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      cmem[wslot_r] <= ocnt_r;
      zmem[wslot_r] <= osize_r;
    end
    cnt_q  <= cmem[rslot_r];
    size_q <= zmem[rslot_r];
  end

  assign out_strobe = out_v_r;
  assign out_data   = out_r;

endmodule
`default_nettype wire

/* rtl/alloc_sample_trace_buffer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alloc_sample_trace_buffer
// Samples allocation events and keeps sampled call stacks in a ring of records.
//
//   Channel  Ports                               Transfer
//   input    start, busy, in_data                start high and busy low
//   result   out_strobe, out_data                out_strobe high, one cycle
//   config   cfg_we, cfg_index, cfg_wdata        cfg_we high
//
// An item is taken in from the idle state and then dispatched. A frame item
// completes in dispatch; an end item that commits copies its frames from the
// open record buffer into the record store. A random sampling decision waits
// on the remainder unit that retires two bits a cycle. A read passes through a
// prefetch state before its first frame, then gives one frame every cycle from
// the record store read port.
// Reset is synchronous; results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module alloc_sample_trace_buffer #(
  parameter int SLOTS      = astb_pkg::SLOTS_DEF,
  parameter int MAX_FRAMES = astb_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire astb_pkg::in_item_t           in_data,
  output logic                              out_strobe,
  output astb_pkg::out_item_t               out_data,
  input  wire logic                         cfg_we,
  input  wire logic [astb_pkg::CFGI_W-1:0]  cfg_index,
  input  wire logic [astb_pkg::CFG_W-1:0]   cfg_wdata
);

  astb_pkg::ctl_t ctl;
  astb_pkg::sts_t sts;

  astb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  astb_dp #(
    .SLOTS      (SLOTS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_data    (in_data),
    .ctl        (ctl),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

/* tb/tb_alloc_sample_trace_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alloc_sample_trace_buffer
// Self-checking bench for the allocation sample trace buffer. A directed table
// covers reset, register extremes and the corner cases of sampling and record
// reads. Random allocate, frame, end and read sequences follow under several
// register settings. Every result transfer is checked against a predictor
// that tracks the generator, the open record and the ring of records.
// ----------------------------------------------------------------------------
module tb_alloc_sample_trace_buffer;

  localparam int NSLOT = astb_pkg::SLOTS_DEF;
  localparam int NFRM  = astb_pkg::MAX_FRAMES_DEF;
  localparam int TARGET_ITEMS = 450;

  typedef struct {
    bit                          is_cfg;
    logic [astb_pkg::CFGI_W-1:0] idx;
    logic [astb_pkg::CFG_W-1:0]  val;
    astb_pkg::in_item_t          item;
    bit                          typed;
    astb_pkg::out_item_t         want;
  } row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  astb_pkg::in_item_t in_data;
  logic out_strobe;
  astb_pkg::out_item_t out_data;
  logic cfg_we;
  logic [astb_pkg::CFGI_W-1:0] cfg_index;
  logic [astb_pkg::CFG_W-1:0] cfg_wdata;

  alloc_sample_trace_buffer u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state.
  logic [astb_pkg::RATE_W-1:0] m_rate;
  logic                        m_en;
  logic [astb_pkg::SEED_W-1:0] m_seed;
  logic [63:0]                 m_gen;
  logic [astb_pkg::PC_W-1:0]   m_store [NSLOT][NFRM];
  logic [astb_pkg::NFRM_W-1:0] m_count [NSLOT];
  logic [astb_pkg::SIZE_W-1:0] m_size [NSLOT];
  bit                          m_ready [NSLOT];
  int                          m_wr, m_rd;
  bit                          m_open;
  int                          m_ocount;
  logic [astb_pkg::SIZE_W-1:0] m_osize;
  logic [astb_pkg::PC_W-1:0]   m_oframes [NFRM];

  astb_pkg::out_item_t due_results[$];
  bit                  cur_typed;
  astb_pkg::out_item_t cur_want;
  int                  errors;
  int                  items;
  bit                  tail;
  bit                  idle_on;
  row_t                rows[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic astb_pkg::out_item_t mk_out(astb_pkg::kind_t k, logic s,
                                                 logic [astb_pkg::PC_W-1:0] pc,
                                                 logic [astb_pkg::SIZE_W-1:0] sz,
                                                 logic [astb_pkg::NFRM_W-1:0] n,
                                                 logic l);
    astb_pkg::out_item_t o;
    o.result_kind = k;
    o.sampled = s;
    o.record_pc = pc;
    o.record_size = sz;
    o.record_frames = n;
    o.last = l;
    return o;
  endfunction

  function automatic astb_pkg::in_item_t mk_in(astb_pkg::cmd_t c,
                                               logic [astb_pkg::SIZE_W-1:0] sz,
                                               logic [astb_pkg::PC_W-1:0] pc,
                                               logic [astb_pkg::NFRM_W-1:0] mf);
    astb_pkg::in_item_t i;
    i.command = c;
    i.alloc_size = sz;
    i.frame_pc = pc;
    i.max_frames = mf;
    return i;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic astb_pkg::in_item_t rnd_item();
    logic [127:0] v;
    v = {rnd64(), rnd64()};
    return v[$bits(astb_pkg::in_item_t)-1:0];
  endfunction

  function automatic void model_reset();
    m_rate = '0;
    m_en = 1'b0;
    m_seed = astb_pkg::SEED_RESET;
    m_gen = '0;
    foreach (m_ready[i]) m_ready[i] = 1'b0;
    m_wr = 0;
    m_rd = 0;
    m_open = 1'b0;
    m_ocount = 0;
    m_osize = '0;
  endfunction

  function automatic bit decide(logic [astb_pkg::SIZE_W-1:0] sz);
    logic [63:0] x;
    if (m_rate == 0 || !m_en) return 1'b0;
    if (m_rate == 1 || {16'b0, sz} > {33'b0, m_rate}) return 1'b1;
    x = m_gen;
    if (x == 0) x = m_seed;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    m_gen = x;
    return (x % {33'b0, m_rate}) <= {16'b0, sz};
  endfunction

  // Advances the predictor by one accepted item and queues its results.
  function automatic void sample_and_record(astb_pkg::in_item_t it);
    bit s;
    int n;
    case (it.command)
      astb_pkg::CMD_ALLOC: begin
        s = decide(it.alloc_size);
        m_open = s;
        m_ocount = 0;
        m_osize = s ? it.alloc_size : '0;
        due_results.push_back(mk_out(astb_pkg::KIND_DECISION, s, '0, '0, '0, 1'b1));
      end
      astb_pkg::CMD_FRAME: begin
        if (m_open && m_ocount < NFRM) begin
          m_oframes[m_ocount] = it.frame_pc;
          m_ocount++;
        end
      end
      astb_pkg::CMD_END: begin
        if (m_open && m_en) begin
          for (int i = 0; i < m_ocount; i++) m_store[m_wr][i] = m_oframes[i];
          m_count[m_wr] = astb_pkg::NFRM_W'(m_ocount);
          m_size[m_wr] = m_osize;
          m_ready[m_wr] = 1'b1;
          m_wr = (m_wr + 1) % NSLOT;
        end
        m_open = 1'b0;
        m_ocount = 0;
      end
      default: begin
        if (!m_ready[m_rd]) begin
          due_results.push_back(mk_out(astb_pkg::KIND_NONE, 1'b0, '0, '0, '0, 1'b1));
        end else begin
          n = int'(m_count[m_rd]);
          if (n > int'(it.max_frames)) n = int'(it.max_frames);
          m_ready[m_rd] = 1'b0;
          if (n == 0) begin
            due_results.push_back(mk_out(astb_pkg::KIND_EMPTY, 1'b0, '0, m_size[m_rd],
                                         '0, 1'b1));
          end else begin
            for (int k = 0; k < n; k++)
              due_results.push_back(mk_out(astb_pkg::KIND_FRAME, 1'b0, m_store[m_rd][k],
                                           m_size[m_rd], astb_pkg::NFRM_W'(n),
                                           k + 1 == n));
          end
          m_rd = (m_rd + 1) % NSLOT;
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    astb_pkg::out_item_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result: got kind=%0d smp=%0b pc=%h size=%h n=%0d last=%0b",
                   $time, out_data.result_kind, out_data.sampled, out_data.record_pc,
                   out_data.record_size, out_data.record_frames, out_data.last);
        end else begin
          want = due_results.pop_front();
          if (out_data !== want) begin
            errors++;
            $display("%0t mismatch: expected kind=%0d smp=%0b pc=%h size=%h n=%0d last=%0b",
                     $time, want.result_kind, want.sampled, want.record_pc,
                     want.record_size, want.record_frames, want.last);
            $display("%0t            actual kind=%0d smp=%0b pc=%h size=%h n=%0d last=%0b",
                     $time, out_data.result_kind, out_data.sampled, out_data.record_pc,
                     out_data.record_size, out_data.record_frames, out_data.last);
          end
        end
      end
      if (start && !busy) begin
        sample_and_record(in_data);
        if (cur_typed) due_results[$] = cur_want;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send(astb_pkg::in_item_t it, bit typed, astb_pkg::out_item_t want);
    if (idle_on && !tail && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    while (busy) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_data = it;
    cur_typed = typed;
    cur_want = want;
    items++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (due_results.size() != 0 || busy) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic cfg_write(logic [astb_pkg::CFGI_W-1:0] idx,
                           logic [astb_pkg::CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      astb_pkg::CFG_SAMPLE_RATE: m_rate = val[astb_pkg::RATE_W-1:0];
      astb_pkg::CFG_ENABLE:      m_en = val[0];
      astb_pkg::CFG_SEED:        m_seed = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic put_cfg(logic [astb_pkg::CFGI_W-1:0] idx,
                         logic [astb_pkg::CFG_W-1:0] val);
    row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    r.typed = 1'b0;
    rows.push_back(r);
  endtask

  task automatic put_item(astb_pkg::in_item_t it, bit typed = 1'b0,
                          astb_pkg::out_item_t want = '0);
    row_t r;
    r.is_cfg = 1'b0;
    r.item = it;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endtask

  task automatic send_plain(astb_pkg::in_item_t it);
    send(it, 1'b0, '0);
  endtask

  initial begin
    logic [astb_pkg::SIZE_W-1:0] sz;
    int nf;
    int phase_len;
    errors = 0;
    items = 0;
    tail = 1'b0;
    idle_on = 1'b1;
    cur_typed = 1'b0;
    cur_want = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    model_reset();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    put_item(mk_in(astb_pkg::CMD_READ, '0, '0, 7'd64), 1'b1,
             mk_out(astb_pkg::KIND_NONE, 1'b0, '0, '0, '0, 1'b1));
    put_item(mk_in(astb_pkg::CMD_ALLOC, '1, '0, '0), 1'b1,
             mk_out(astb_pkg::KIND_DECISION, 1'b0, '0, '0, '0, 1'b1));
    put_cfg(astb_pkg::CFG_SAMPLE_RATE, 64'd1);
    put_cfg(astb_pkg::CFG_ENABLE, 64'd1);
    put_item(mk_in(astb_pkg::CMD_ALLOC, '1, '0, '0), 1'b1,
             mk_out(astb_pkg::KIND_DECISION, 1'b1, '0, '0, '0, 1'b1));
    put_item(mk_in(astb_pkg::CMD_FRAME, '0, '0, '0));
    put_item(mk_in(astb_pkg::CMD_FRAME, '0, '1, '0));
    put_item(mk_in(astb_pkg::CMD_END, '0, '0, '0));
    put_item(mk_in(astb_pkg::CMD_READ, '0, '0, 7'd64));
    put_item(mk_in(astb_pkg::CMD_READ, '0, '0, 7'd64), 1'b1,
             mk_out(astb_pkg::KIND_NONE, 1'b0, '0, '0, '0, 1'b1));
    put_item(mk_in(astb_pkg::CMD_ALLOC, '0, '0, '0), 1'b1,
             mk_out(astb_pkg::KIND_DECISION, 1'b1, '0, '0, '0, 1'b1));
    put_item(mk_in(astb_pkg::CMD_END, '0, '0, '0));
    put_item(mk_in(astb_pkg::CMD_READ, '0, '0, 7'd64), 1'b1,
             mk_out(astb_pkg::KIND_EMPTY, 1'b0, '0, '0, '0, 1'b1));
    put_item(mk_in(astb_pkg::CMD_ALLOC, 48'd5, '0, '0));
    put_item(mk_in(astb_pkg::CMD_FRAME, '0, 64'h1234, '0));
    put_item(mk_in(astb_pkg::CMD_END, '0, '0, '0));
    put_item(mk_in(astb_pkg::CMD_READ, '0, '0, 7'd0), 1'b1,
             mk_out(astb_pkg::KIND_EMPTY, 1'b0, '0, 48'd5, '0, 1'b1));
    put_item(mk_in(astb_pkg::CMD_FRAME, '0, 64'h55, '0));
    put_item(mk_in(astb_pkg::CMD_END, '0, '0, '0));
    put_item(mk_in(astb_pkg::CMD_ALLOC, 48'd9, 64'hA, '0));
    put_item(mk_in(astb_pkg::CMD_FRAME, '0, 64'hA, '0));
    put_item(mk_in(astb_pkg::CMD_ALLOC, 48'd11, '0, '0));
    put_item(mk_in(astb_pkg::CMD_FRAME, '0, 64'hB, '0));
    put_item(mk_in(astb_pkg::CMD_END, '0, '0, '0));
    put_item(mk_in(astb_pkg::CMD_READ, '0, '0, 7'd64));
    // The generator is still zero, so a zero seed keeps every draw at zero.
    put_cfg(astb_pkg::CFG_SEED, 64'd0);
    put_cfg(astb_pkg::CFG_SAMPLE_RATE, 64'h7FFF_FFFF);
    put_item(mk_in(astb_pkg::CMD_ALLOC, '0, '0, '0), 1'b1,
             mk_out(astb_pkg::KIND_DECISION, 1'b1, '0, '0, '0, 1'b1));
    put_cfg(astb_pkg::CFG_SEED, '1);
    put_item(mk_in(astb_pkg::CMD_ALLOC, 48'h8000_0000, '0, '0), 1'b1,
             mk_out(astb_pkg::KIND_DECISION, 1'b1, '0, '0, '0, 1'b1));
    put_item(mk_in(astb_pkg::CMD_FRAME, '0, 64'hC, '0));
    put_cfg(astb_pkg::CFG_ENABLE, 64'd0);
    put_item(mk_in(astb_pkg::CMD_END, '0, '0, '0));
    put_item(mk_in(astb_pkg::CMD_READ, '0, '0, 7'd64), 1'b1,
             mk_out(astb_pkg::KIND_NONE, 1'b0, '0, '0, '0, 1'b1));
    put_item(mk_in(astb_pkg::CMD_ALLOC, '1, '0, '0), 1'b1,
             mk_out(astb_pkg::KIND_DECISION, 1'b0, '0, '0, '0, 1'b1));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_idle();
        cfg_write(rows[i].idx, rows[i].val);
      end else begin
        send(rows[i].item, rows[i].typed, rows[i].want);
      end
    end

    while (items < TARGET_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0: cfg_write(astb_pkg::CFG_SAMPLE_RATE, 64'd0);
        1: cfg_write(astb_pkg::CFG_SAMPLE_RATE, 64'd1);
        2: cfg_write(astb_pkg::CFG_SAMPLE_RATE,
                     astb_pkg::CFG_W'($urandom_range(2, 64)));
        3: cfg_write(astb_pkg::CFG_SAMPLE_RATE,
                     astb_pkg::CFG_W'($urandom_range(2, 1 << 20)));
        4: cfg_write(astb_pkg::CFG_SAMPLE_RATE, 64'h7FFF_FFFF);
        default: cfg_write(astb_pkg::CFG_SAMPLE_RATE, rnd64());
      endcase
      cfg_write(astb_pkg::CFG_ENABLE, {63'b0, $urandom_range(0, 5) != 0});
      cfg_write(astb_pkg::CFG_SEED, ($urandom_range(0, 7) == 0) ? 64'd0 : rnd64());
      idle_on = $urandom_range(0, 3) != 0;
      phase_len = items + $urandom_range(20, 50);
      while (items < phase_len && items < TARGET_ITEMS) begin
        tail = items > TARGET_ITEMS - 60;
        case ($urandom_range(0, 9))
          0: send_plain(rnd_item());
          1, 2: send_plain(mk_in(astb_pkg::CMD_READ, astb_pkg::SIZE_W'(rnd64()), rnd64(),
                                 astb_pkg::NFRM_W'($urandom_range(0, 64))));
          default: begin
            if (m_rate > 1 && $urandom_range(0, 1))
              sz = astb_pkg::SIZE_W'($urandom_range(0, m_rate));
            else sz = astb_pkg::SIZE_W'(rnd64());
            send_plain(mk_in(astb_pkg::CMD_ALLOC, sz, rnd64(), astb_pkg::NFRM_W'(rnd64())));
            nf = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 67) : $urandom_range(0, 6);
            repeat (nf)
              send_plain(mk_in(astb_pkg::CMD_FRAME, astb_pkg::SIZE_W'(rnd64()), rnd64(),
                               astb_pkg::NFRM_W'(rnd64())));
            send_plain(mk_in(astb_pkg::CMD_END, astb_pkg::SIZE_W'(rnd64()), rnd64(),
                             astb_pkg::NFRM_W'(rnd64())));
            if ($urandom_range(0, 1))
              send_plain(mk_in(astb_pkg::CMD_READ, astb_pkg::SIZE_W'(rnd64()), rnd64(),
                               astb_pkg::NFRM_W'($urandom_range(0, 64))));
          end
        endcase
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
